// ----- design/ibp_pkg.sv -----
// Shared types and constants for the iBus frame parser.
// No dependencies; imported by the front, back and top-level modules.
`default_nettype none

package ibp_pkg;

  // Widest payload write index carried between front and back
  localparam int unsigned IDX_W = 6;

  // Parser phases
  localparam logic [2:0] PH_LENGTH   = 3'd0;
  localparam logic [2:0] PH_COMMAND  = 3'd1;
  localparam logic [2:0] PH_PAYLOAD  = 3'd2;
  localparam logic [2:0] PH_CHECK_LO = 3'd3;
  localparam logic [2:0] PH_CHECK_HI = 3'd4;

  localparam logic [7:0]  LEN_MIN     = 8'h05;
  localparam logic [7:0]  LEN_MAX     = 8'h20;
  localparam logic [7:0]  SERVO_CMD   = 8'h40;
  localparam logic [7:0]  OVERHEAD    = 8'h04;
  localparam logic [15:0] CHK_INIT    = 16'hFFFF;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] addr;
    logic [7:0]       data;
  } store_wr_t;

endpackage

`default_nettype wire

// ----- design/ibp_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ibp_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 32
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// ----- design/ibp_front.sv -----
// Front end: byte-level frame parser, checksum tracking and payload writes.
// Depends on ibp_pkg; feeds ibp_back with store writes and frame tokens.
`default_nettype none

module ibp_front #(
  parameter int unsigned STORE_BYTES = 32
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                accept_i,
  input  wire logic                kind_i,
  input  wire logic [7:0]          byte_value_i,
  input  wire logic                back_busy_i,
  output logic                     stall_o,
  output ibp_pkg::store_wr_t       wr_o,
  output logic                     frame_ok_o
);
  import ibp_pkg::*;

  logic [2:0]       phase_q, phase_d;
  logic [4:0]       pay_cnt_q, pay_cnt_d;
  logic [7:0]       cmd_q, cmd_d;
  logic [15:0]      chk_q, chk_d;
  logic [7:0]       chk_lo_q, chk_lo_d;
  logic [IDX_W-1:0] wr_idx_q, wr_idx_d;
  logic [IDX_W-1:0] idx_nx;

  // payload bytes and the frame end wait while the back end reads the store
  assign stall_o = back_busy_i && (phase_q == PH_PAYLOAD || phase_q == PH_CHECK_HI);

  assign idx_nx = wr_idx_q + 1'b1;

  always_comb begin
    phase_d    = phase_q;
    pay_cnt_d  = pay_cnt_q;
    cmd_d      = cmd_q;
    chk_d      = chk_q;
    chk_lo_d   = chk_lo_q;
    wr_idx_d   = wr_idx_q;
    wr_o       = '0;
    frame_ok_o = 1'b0;
    if (accept_i) begin
      if (kind_i) begin
        phase_d = PH_LENGTH;
      end else begin
        case (phase_q)
          PH_COMMAND: begin
            cmd_d   = byte_value_i;
            chk_d   = chk_q - {8'h00, byte_value_i};
            phase_d = PH_PAYLOAD;
          end
          PH_PAYLOAD: begin
            wr_o.en   = ({1'b0, wr_idx_q} < (IDX_W+1)'(STORE_BYTES));
            wr_o.addr = wr_idx_q;
            wr_o.data = byte_value_i;
            wr_idx_d  = idx_nx;
            chk_d     = chk_q - {8'h00, byte_value_i};
            if (idx_nx == IDX_W'(pay_cnt_q) ||
                {1'b0, idx_nx} >= (IDX_W+1)'(STORE_BYTES)) begin
              phase_d = PH_CHECK_LO;
            end
          end
          PH_CHECK_LO: begin
            chk_lo_d = byte_value_i;
            phase_d  = PH_CHECK_HI;
          end
          PH_CHECK_HI: begin
            phase_d    = PH_LENGTH;
            frame_ok_o = ({byte_value_i, chk_lo_q} == chk_q) && (cmd_q == SERVO_CMD);
          end
          default: begin
            // hunting for a length byte; unused phase codes land here too
            if (byte_value_i inside {[LEN_MIN:LEN_MAX]}) begin
              phase_d   = PH_COMMAND;
              wr_idx_d  = '0;
              pay_cnt_d = 5'(byte_value_i - OVERHEAD);
              chk_d     = CHK_INIT - {8'h00, byte_value_i};
            end else begin
              phase_d = PH_LENGTH;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_LENGTH;
      pay_cnt_q <= '0;
      cmd_q     <= '0;
      chk_q     <= '0;
      chk_lo_q  <= '0;
      wr_idx_q  <= '0;
    end else begin
      phase_q   <= phase_d;
      pay_cnt_q <= pay_cnt_d;
      cmd_q     <= cmd_d;
      chk_q     <= chk_d;
      chk_lo_q  <= chk_lo_d;
      wr_idx_q  <= wr_idx_d;
    end
  end

endmodule

`default_nettype wire

// ----- design/ibp_back.sv -----
// Back end: payload store, frame token queue and per-channel result sequencer.
// Depends on ibp_pkg and ibp_ram; driven by ibp_front.
`default_nettype none

module ibp_back #(
  parameter int unsigned CHANNELS    = 14,
  parameter int unsigned STORE_BYTES = 32
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  ibp_pkg::store_wr_t      wr_i,
  input  wire logic               frame_ok_i,
  input  wire logic               pop_i,
  output logic                    busy_o,
  output logic                    out_valid_o,
  output logic [3:0]              channel_index_o,
  output logic [15:0]             channel_value_o,
  output logic                    last_o
);
  import ibp_pkg::*;

  localparam int unsigned AW = $clog2(STORE_BYTES);
  localparam int unsigned CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_LO   = 2'd1;
  localparam logic [1:0] ST_HI   = 2'd2;
  localparam logic [1:0] ST_OUT  = 2'd3;

  logic [1:0]             state_q, state_d;
  logic                   pend_q, pend_d;
  logic [CW-1:0]          ch_q, ch_d;
  logic [7:0]             lo_q, lo_d;
  logic                   rd_ok_q, rd_ok_d;
  logic [STORE_BYTES-1:0] valid_q;
  logic                   out_v_q, out_v_d;
  logic [3:0]             out_idx_q, out_idx_d;
  logic [15:0]            out_val_q, out_val_d;
  logic                   out_last_q, out_last_d;

  logic          rd_en;
  logic [CW:0]   rd_pos;
  logic          rd_in_range;
  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_data;
  logic [7:0]    rd_byte;
  logic          ch_last;
  logic          out_free;

  ibp_ram #(
    .WIDTH (8),
    .DEPTH (STORE_BYTES)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (wr_i.en),
    .waddr_i (AW'(wr_i.addr)),
    .wdata_i (wr_i.data),
    .re_i    (rd_en),
    .raddr_i (rd_addr),
    .rdata_o (rd_data)
  );

  // positions past the store, and entries never written, read as zero
  assign rd_pos      = {ch_q, (state_q == ST_HI)};
  assign rd_in_range = (8'(rd_pos) < 8'(STORE_BYTES));
  assign rd_addr     = AW'(rd_pos);
  assign rd_en       = (state_q == ST_LO) || (state_q == ST_HI);
  assign rd_byte     = rd_ok_q ? rd_data : 8'h00;
  assign ch_last     = (ch_q == CW'(CHANNELS - 1));
  assign out_free    = !out_v_q || pop_i;

  assign busy_o = pend_q || (state_q != ST_IDLE);

  always_comb begin
    state_d    = state_q;
    pend_d     = pend_q || frame_ok_i;
    ch_d       = ch_q;
    lo_d       = lo_q;
    rd_ok_d    = rd_ok_q;
    out_v_d    = out_v_q && !pop_i;
    out_idx_d  = out_idx_q;
    out_val_d  = out_val_q;
    out_last_d = out_last_q;
    if (rd_en) begin
      rd_ok_d = rd_in_range && valid_q[rd_addr];
    end
    case (state_q)
      ST_IDLE: begin
        if (pend_q) begin
          pend_d  = 1'b0;
          ch_d    = '0;
          state_d = ST_LO;
        end
      end
      ST_LO: begin
        state_d = ST_HI;
      end
      ST_HI: begin
        lo_d    = rd_byte;
        state_d = ST_OUT;
      end
      ST_OUT: begin
        if (out_free) begin
          out_v_d    = 1'b1;
          out_idx_d  = 4'(ch_q);
          out_val_d  = {rd_byte, lo_q};
          out_last_d = ch_last;
          if (ch_last) begin
            state_d = ST_IDLE;
          end else begin
            ch_d    = ch_q + 1'b1;
            state_d = ST_LO;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      pend_q  <= 1'b0;
      valid_q <= '0;
      out_v_q <= 1'b0;
    end else begin
      state_q <= state_d;
      pend_q  <= pend_d;
      out_v_q <= out_v_d;
      if (wr_i.en) begin
        valid_q[AW'(wr_i.addr)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    ch_q       <= ch_d;
    lo_q       <= lo_d;
    rd_ok_q    <= rd_ok_d;
    out_idx_q  <= out_idx_d;
    out_val_q  <= out_val_d;
    out_last_q <= out_last_d;
  end

  assign out_valid_o     = out_v_q;
  assign channel_index_o = out_idx_q;
  assign channel_value_o = out_val_q;
  assign last_o          = out_last_q;

endmodule

`default_nettype wire

// ----- design/ibus_frame_parser.sv -----
// Receiver frame parser: takes serial bytes one beat at a time, checks the
// length, command and 16-bit checksum of each frame, and on a good servo frame
// emits one beat per channel (little-endian value from payload byte pairs,
// last set on the final channel). After a good frame the back sequencer works
// channel by channel: a registered read of each byte of the payload pair, then
// the output register, which waits while an earlier result is still unpopped.
// While that burst runs, payload and checksum-high beats are held off by full;
// length, command and checksum-low beats are still taken. Bytes beyond a short
// frame keep earlier values; never-written store entries read as zero.
// Depends on ibp_pkg, ibp_front, ibp_back and ibp_ram.
`default_nettype none

module ibus_frame_parser #(
  parameter int unsigned CHANNELS    = 14,
  parameter int unsigned STORE_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  output logic             full,
  input  wire logic        kind_i,
  input  wire logic [7:0]  byte_value_i,
  output logic             empty,
  input  wire logic        pop,
  output logic [3:0]       channel_index_o,
  output logic [15:0]      channel_value_o,
  output logic             last_o
);
  import ibp_pkg::*;

  store_wr_t store_wr;
  logic      frame_ok;
  logic      back_busy;
  logic      stall;
  logic      accept;
  logic      out_valid;

  assign full   = stall;
  assign accept = push && !stall;
  assign empty  = !out_valid;

  ibp_front #(
    .STORE_BYTES (STORE_BYTES)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .accept_i     (accept),
    .kind_i       (kind_i),
    .byte_value_i (byte_value_i),
    .back_busy_i  (back_busy),
    .stall_o      (stall),
    .wr_o         (store_wr),
    .frame_ok_o   (frame_ok)
  );

  ibp_back #(
    .CHANNELS    (CHANNELS),
    .STORE_BYTES (STORE_BYTES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .wr_i            (store_wr),
    .frame_ok_i      (frame_ok),
    .pop_i           (pop && out_valid),
    .busy_o          (back_busy),
    .out_valid_o     (out_valid),
    .channel_index_o (channel_index_o),
    .channel_value_o (channel_value_o),
    .last_o          (last_o)
  );

endmodule

`default_nettype wire

// ----- dv/ibp_frame_checker.sv -----
// Checker for the iBus frame parser: tracks the parser state from accepted byte
// beats, queues the channel beats each good servo frame should produce, and
// compares every popped channel beat against them. Depends on ibp_pkg.
`timescale 1ns / 100ps

module ibp_frame_checker
  import ibp_pkg::*;
#(
  parameter int unsigned CHANNELS    = 14,
  parameter int unsigned STORE_BYTES = 32
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        push,
  input  wire logic        full,
  input  wire logic        kind_i,
  input  wire logic [7:0]  byte_value_i,
  input  wire logic        empty,
  input  wire logic        pop,
  input  wire logic [3:0]  channel_index_i,
  input  wire logic [15:0] channel_value_i,
  input  wire logic        last_i,
  output int unsigned      mismatch_count_o,
  output int unsigned      outstanding_o
);

  typedef struct packed {
    logic [3:0]  ch_index;
    logic [15:0] ch_value;
    logic        ch_last;
  } channel_beat_t;

  channel_beat_t channel_q[$];

  logic [2:0]  phase_q;
  logic [4:0]  count_q;
  logic [7:0]  cmd_q;
  logic [15:0] chk_q;
  logic [7:0]  chk_lo_q;
  logic [7:0]  store_q [STORE_BYTES];
  logic [5:0]  wr_idx_q;
  int unsigned fails;

  function automatic logic [7:0] store_byte(input int unsigned pos);
    if (pos < STORE_BYTES) return store_q[pos];
    return 8'h00;
  endfunction

  // Advance the parser by one accepted byte beat, queueing channel beats on a
  // good servo frame.
  function automatic void parse_byte(input logic k, input logic [7:0] b);
    channel_beat_t beat;
    logic [15:0]   rx_chk;
    if (k) begin
      phase_q = PH_LENGTH;
      return;
    end
    case (phase_q)
      PH_COMMAND: begin
        cmd_q   = b;
        chk_q   = chk_q - 16'(b);
        phase_q = PH_PAYLOAD;
      end
      PH_PAYLOAD: begin
        if (wr_idx_q < STORE_BYTES) store_q[wr_idx_q] = b;
        wr_idx_q = wr_idx_q + 6'd1;
        chk_q    = chk_q - 16'(b);
        if (wr_idx_q == {1'b0, count_q} || wr_idx_q >= STORE_BYTES) phase_q = PH_CHECK_LO;
      end
      PH_CHECK_LO: begin
        chk_lo_q = b;
        phase_q  = PH_CHECK_HI;
      end
      PH_CHECK_HI: begin
        rx_chk  = {b, chk_lo_q};
        phase_q = PH_LENGTH;
        if (rx_chk == chk_q && cmd_q == SERVO_CMD) begin
          for (int unsigned i = 0; i < CHANNELS; i++) begin
            beat.ch_index = 4'(i);
            beat.ch_value = {store_byte(2 * i + 1), store_byte(2 * i)};
            beat.ch_last  = (i == CHANNELS - 1);
            channel_q.push_back(beat);
          end
        end
      end
      default: begin
        // hunting: out-of-range length bytes are dropped
        if (b >= LEN_MIN && b <= LEN_MAX) begin
          phase_q  = PH_COMMAND;
          wr_idx_q = '0;
          count_q  = 5'(b - OVERHEAD);
          chk_q    = CHK_INIT - 16'(b);
        end else begin
          phase_q = PH_LENGTH;
        end
      end
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    channel_beat_t exp_beat;
    if (!rst_ni) begin
      phase_q  = PH_LENGTH;
      count_q  = '0;
      cmd_q    = '0;
      chk_q    = '0;
      chk_lo_q = '0;
      wr_idx_q = '0;
      for (int i = 0; i < STORE_BYTES; i++) store_q[i] = 8'h00;
      channel_q.delete();
      fails = 0;
      mismatch_count_o <= 0;
      outstanding_o    <= 0;
    end else begin
      if (pop && !empty) begin
        if (channel_q.size() == 0) begin
          $error("unexpected channel beat: index %0d value 0x%04h last %0b",
                 channel_index_i, channel_value_i, last_i);
          fails++;
        end else begin
          exp_beat = channel_q.pop_front();
          if (exp_beat.ch_index !== channel_index_i) begin
            $error("channel_index: expected %0d, got %0d", exp_beat.ch_index, channel_index_i);
            fails++;
          end
          if (exp_beat.ch_value !== channel_value_i) begin
            $error("channel_value: expected 0x%04h, got 0x%04h",
                   exp_beat.ch_value, channel_value_i);
            fails++;
          end
          if (exp_beat.ch_last !== last_i) begin
            $error("last: expected %0b, got %0b", exp_beat.ch_last, last_i);
            fails++;
          end
        end
      end
      if (push && !full) parse_byte(kind_i, byte_value_i);
      mismatch_count_o <= fails;
      outstanding_o    <= channel_q.size();
    end
  end

endmodule

// ----- dv/tb_ibus_frame_parser.sv -----
// Testbench top for ibus_frame_parser: drives byte beats (good, corrupt,
// foreign-command and aborted frames plus noise), pops channel beats, and
// gives the verdict. Depends on ibp_pkg, the parser RTL and ibp_frame_checker.
`timescale 1ns / 100ps

module tb_ibus_frame_parser;
  import ibp_pkg::*;

  localparam int unsigned STALL_LIMIT   = 2000;
  localparam int unsigned RANDOM_BEATS  = 200;

  logic        clk_i;
  logic        rst_ni       = 1'b0;
  logic        push         = 1'b0;
  logic        kind_i       = 1'b0;
  logic [7:0]  byte_value_i = 8'h00;
  logic        pop          = 1'b0;
  logic        full;
  logic        empty;
  logic [3:0]  channel_index_o;
  logic [15:0] channel_value_o;
  logic        last_o;

  int unsigned mismatch_count;
  int unsigned outstanding;
  int unsigned beats_sent   = 0;
  int unsigned results_seen = 0;
  int unsigned stall_cycles = 0;
  logic        no_idle      = 1'b0;

  ibus_frame_parser #(.CHANNELS(14), .STORE_BYTES(32)) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .push           (push),
    .full           (full),
    .kind_i         (kind_i),
    .byte_value_i   (byte_value_i),
    .empty          (empty),
    .pop            (pop),
    .channel_index_o(channel_index_o),
    .channel_value_o(channel_value_o),
    .last_o         (last_o)
  );

  ibp_frame_checker #(.CHANNELS(14), .STORE_BYTES(32)) u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .push            (push),
    .full            (full),
    .kind_i          (kind_i),
    .byte_value_i    (byte_value_i),
    .empty           (empty),
    .pop             (pop),
    .channel_index_i (channel_index_o),
    .channel_value_i (channel_value_o),
    .last_i          (last_o),
    .mismatch_count_o(mismatch_count),
    .outstanding_o   (outstanding)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // receiver side: random pop stalls
  always @(posedge clk_i) begin
    if (!rst_ni) pop <= 1'b0;
    else pop <= no_idle || ($urandom_range(99) >= 8);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (pop && !empty) results_seen++;
      if ((push && !full) || (pop && !empty)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("FAIL");
          $finish;
        end
      end
    end
  end

  task automatic send_beat(input logic k, input logic [7:0] b);
    while (!no_idle && $urandom_range(99) < 8) begin
      push <= 1'b0;
      @(posedge clk_i);
    end
    push         <= 1'b1;
    kind_i       <= k;
    byte_value_i <= b;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    beats_sent++;
  endtask

  // Hold the sender until every queued channel beat has been popped.
  task automatic wait_drained();
    push <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
  endtask

  function automatic logic [7:0] payload_byte();
    case ($urandom_range(9))
      0:       return 8'h00;
      1:       return 8'hFF;
      default: return 8'($urandom_range(255));
    endcase
  endfunction

  // One frame; bad_chk flips a checksum bit, abort_at > 0 cuts the frame after
  // that many beats and follows with a restart.
  task automatic send_frame(input logic [7:0] len, input logic [7:0] cmd,
                            input bit bad_chk, input int abort_at);
    logic [7:0]  fr[$];
    logic [15:0] sum;
    logic [15:0] chk;
    fr.push_back(len);
    fr.push_back(cmd);
    for (int i = 0; i < int'(len) - 4; i++) fr.push_back(payload_byte());
    sum = '0;
    foreach (fr[i]) sum += 16'(fr[i]);
    chk = CHK_INIT - sum;
    if (bad_chk) chk ^= 16'(1) << $urandom_range(15);
    fr.push_back(chk[7:0]);
    fr.push_back(chk[15:8]);
    foreach (fr[i]) begin
      if (abort_at > 0 && i == abort_at) break;
      send_beat(1'b0, fr[i]);
    end
    if (abort_at > 0) send_beat(1'b1, 8'($urandom_range(255)));
  endtask

  initial begin
    int unsigned frame_no;
    int unsigned pick;
    logic [7:0]  len;
    logic [7:0]  cmd;

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // lengths just past both limits and at the byte extremes are dropped while hunting
    send_beat(1'b0, 8'h04);
    send_beat(1'b0, 8'h21);
    send_beat(1'b0, 8'h00);
    send_beat(1'b0, 8'hFF);
    send_beat(1'b1, 8'hFF);
    // shortest frame: later channels read never-written store entries as zero
    send_frame(LEN_MIN, SERVO_CMD, 1'b0, 0);
    send_frame(LEN_MIN, SERVO_CMD, 1'b1, 0);
    send_frame(LEN_MIN, SERVO_CMD ^ 8'h01, 1'b0, 0);
    wait_drained();

    frame_no = 0;
    while (beats_sent < RANDOM_BEATS) begin
      no_idle = (frame_no >= 3 && frame_no < 8);
      if (frame_no == 6) wait_drained();
      pick = $urandom_range(99);
      if (pick < 50) len = 8'($urandom_range(10, 5));
      else if (pick < 85) len = 8'($urandom_range(32, 5));
      else len = LEN_MAX;
      cmd  = SERVO_CMD;
      pick = $urandom_range(99);
      if (pick < 65) begin
        send_frame(len, cmd, 1'b0, 0);
      end else if (pick < 75) begin
        send_frame(len, cmd, 1'b1, 0);
      end else if (pick < 83) begin
        cmd = 8'($urandom_range(255));
        if (cmd == SERVO_CMD) cmd ^= 8'h80;
        send_frame(len, cmd, 1'b0, 0);
      end else if (pick < 92) begin
        send_frame(len, cmd, 1'b0, $urandom_range(int'(len) - 1, 1));
      end else begin
        repeat ($urandom_range(4, 1)) send_beat(1'b0, 8'($urandom_range(255)));
        send_beat(1'b1, 8'($urandom_range(255)));
      end
      frame_no++;
    end
    no_idle = 1'b0;

    wait_drained();
    repeat (80) @(posedge clk_i);
    $display("Covered %0d byte beats over %0d random frames or noise bursts,", beats_sent,
             frame_no);
    $display("with %0d channel results checked.", results_seen);
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule
